@@ design/srtk_pkg.sv @@
// Shared types for the sorted record table: record layout, decoded command and
// the sort-order compare. No dependencies; used by srtk_front and srtk_back.
package srtk_pkg;

    localparam int NAME_W  = 64;
    localparam int AGE_W   = 8;
    localparam int WORTH_W = 21;
    localparam int LIM_W   = 7;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 96;

    // name in the low bits, then age, then worth
    typedef struct packed {
        logic [WORTH_W-1:0] worth;
        logic [AGE_W-1:0]   age;
        logic [NAME_W-1:0]  name;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             is_query;
        logic [LIM_W-1:0] limit;
        logic [AGE_W-1:0] age_lo;
        logic [AGE_W-1:0] age_hi;
        entry_t           rec;
    } cmd_t;

    // true when x sorts ahead of y: worth descending, age ascending, name ascending
    function automatic logic goes_before(input entry_t x, input entry_t y);
        logic res;
        if (x.worth != y.worth) begin
            res = $signed(x.worth) > $signed(y.worth);
        end else if (x.age != y.age) begin
            res = x.age < y.age;
        end else begin
            res = x.name < y.name;
        end
        return res;
    endfunction

endpackage

@@ design/srtk_front.sv @@
// Front end: accepts input beats, decodes them into commands and queues them
// in a two-entry FIFO for the back end. Depends on srtk_pkg.
module srtk_front #(
    parameter int MAX_OUT = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srtk_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output srtk_pkg::cmd_t                    cmd
);
    import srtk_pkg::*;

    cmd_t        fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    cmd_t        dec;
    logic [LIM_W-1:0] want;
    logic        push, pop;

    // classify the incoming beat and saturate the count
    always_comb begin
        want          = s_tdata[99:93];
        dec.is_query  = s_tuser;
        dec.limit     = (want > LIM_W'(MAX_OUT)) ? LIM_W'(MAX_OUT) : want;
        dec.age_lo    = s_tdata[107:100];
        dec.age_hi    = s_tdata[115:108];
        dec.rec.name  = s_tdata[63:0];
        dec.rec.age   = s_tdata[71:64];
        dec.rec.worth = s_tdata[92:72];
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ design/srtk_back.sv @@
// Back end: holds the sorted record memory, runs inserts by shifting entries
// one per cycle and queries by scanning one entry per cycle while the output
// register can take matches; owns the output register. Depends on srtk_pkg.
module srtk_back #(
    parameter int DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  srtk_pkg::cmd_t                    cmd,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srtk_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import srtk_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_EVAL,
        ST_INS_PUT,
        ST_Q_EVAL,
        ST_Q_FLUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [LIM_W-1:0]   n_reg, n_next;
    cmd_t               cmd_reg, cmd_next;
    logic               pend_valid_reg, pend_valid_next;
    entry_t             pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    entry_t             out_entry_reg, out_entry_next;
    logic               out_none_reg, out_none_next;
    logic               out_last_reg, out_last_next;

    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    logic               rd_en, wr_en;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    entry_t             wr_data;

    logic               slot_free, push, push_none, push_last;
    entry_t             push_entry;
    logic               match, stall, done;
    logic [CNT_W-1:0]   count_m1, pos_m1, pos_m2, idx_p1;
    logic [LIM_W-1:0]   n_p1;

    assign slot_free = !out_valid_reg || m_tready;
    assign count_m1  = count_reg - 1'b1;
    assign pos_m1    = pos_reg - 1'b1;
    assign pos_m2    = pos_reg - 2'd2;
    assign idx_p1    = idx_reg + 1'b1;
    assign n_p1      = n_reg + 1'b1;
    assign match     = (rdata_reg.age >= cmd_reg.age_lo) && (rdata_reg.age <= cmd_reg.age_hi);
    assign stall     = match && pend_valid_reg && !slot_free;
    assign done      = (idx_p1 == count_reg) || (match && (n_p1 == cmd_reg.limit));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        cmd_next        = cmd_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_ready       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rdata_reg;
        push            = 1'b0;
        push_entry      = pend_reg;
        push_none       = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    cmd_next  = cmd;
                    if (!cmd.is_query) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            // table full: drop
                        end else if (count_reg == '0) begin
                            wr_en      = 1'b1;
                            wr_data    = cmd.rec;
                            count_next = count_reg + 1'b1;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = count_m1[ADDR_W-1:0];
                            pos_next   = count_reg;
                            state_next = ST_INS_EVAL;
                        end
                    end else begin
                        n_next          = '0;
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        if (count_reg == '0 || cmd.limit == '0) begin
                            state_next = ST_Q_FLUSH;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_Q_EVAL;
                        end
                    end
                end
            end
            ST_INS_EVAL: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[ADDR_W-1:0];
                if (goes_before(cmd_reg.rec, rdata_reg)) begin
                    // move the stored entry down one slot
                    wr_data  = rdata_reg;
                    pos_next = pos_m1;
                    if (pos_m1 == '0) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_m2[ADDR_W-1:0];
                    end
                end else begin
                    wr_data    = cmd_reg.rec;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[ADDR_W-1:0];
                wr_data    = cmd_reg.rec;
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_EVAL: begin
                if (!stall) begin
                    if (match) begin
                        // release the held match; the new one may be the last
                        push            = pend_valid_reg;
                        pend_next       = rdata_reg;
                        pend_valid_next = 1'b1;
                        n_next          = n_p1;
                    end
                    if (done) begin
                        state_next = ST_Q_FLUSH;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_p1[ADDR_W-1:0];
                        idx_next = idx_p1;
                    end
                end
            end
            ST_Q_FLUSH: begin
                if (slot_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    push_none  = !pend_valid_reg;
                    push_entry = pend_valid_reg ? pend_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = push ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_entry_next = push ? push_entry : out_entry_reg;
        out_none_next  = push ? push_none : out_none_reg;
        out_last_next  = push ? push_last : out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        n_reg         <= n_next;
        cmd_reg       <= cmd_next;
        pend_reg      <= pend_next;
        out_entry_reg <= out_entry_next;
        out_none_reg  <= out_none_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - ENTRY_W){1'b0}}, out_entry_reg};
    assign m_tuser  = out_none_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1))
        else $error("record count moved by more than one");

    a_scan_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_EVAL) |-> (n_reg < cmd_reg.limit))
        else $error("scan continued past query limit");

    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_none_reg) |-> out_last_reg)
        else $error("none result not marked last");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> slot_free)
        else $error("result loaded over a pending beat");

endmodule

@@ design/sorted_record_top_k_range_query_top.sv @@
// Sorted record table with top-K age-range query: top level.
// Depends on srtk_pkg, srtk_front and srtk_back.
//
// Records (name, age, signed worth) are kept sorted by worth descending, then
// age ascending, then name ascending, in a single-port-write, single-read
// memory of DEPTH entries. An insert (s_tuser = 0) shifts each entry that sorts
// behind the new record one slot further back, one memory shift per cycle, then
// writes the record in the gap; an insert into an empty table writes it directly,
// and inserts into a full table are dropped. A query (s_tuser = 1) scans from
// the front at one entry per cycle while the output register can take results,
// and returns up to min(want_count, MAX_OUT) matching records with m_tlast on
// the final beat, or one beat with m_tuser set when nothing matches or
// want_count is zero.
// A two-entry command queue lets new beats be taken while the engine works, and
// the output register lets the engine proceed while a result waits. No clearing
// pass is needed after reset.
module sorted_record_top_k_range_query_top #(
    parameter int DEPTH   = 1024,
    parameter int MAX_OUT = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rec_name[63:0], rec_age[71:64], rec_worth[92:72], want_count[99:93],
    // age_min[107:100], age_max[115:108], zero fill
    input  logic [srtk_pkg::IN_DATA_W-1:0]    s_tdata,
    // cmd
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_name[63:0], out_age[71:64], out_worth[92:72], zero fill
    output logic [srtk_pkg::OUT_DATA_W-1:0]   m_tdata,
    // none_found
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import srtk_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    srtk_front #(
        .MAX_OUT (MAX_OUT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    srtk_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ dv/tb_sorted_record_top_k_range_query_top.sv @@
// Testbench for the sorted record table with top-K age-range query.
// Needs srtk_pkg and sorted_record_top_k_range_query_top; a scoreboard class
// mirrors the sorted table and checks every result beat in order.
`timescale 1ns / 100ps

module tb_sorted_record_top_k_range_query_top;

    import srtk_pkg::*;

    localparam int TBL_DEPTH  = 1024;
    localparam int TOP_MAX    = 64;
    localparam int AGE_LSB    = NAME_W;
    localparam int WORTH_LSB  = AGE_LSB + AGE_W;
    localparam int CNT_LSB    = WORTH_LSB + WORTH_W;
    localparam int LO_LSB     = CNT_LSB + LIM_W;
    localparam int HI_LSB     = LO_LSB + AGE_W;
    localparam int NOISE_W    = HI_LSB + AGE_W - CNT_LSB;
    localparam int CYCLE_CAP  = 5_000_000;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_LEN  = 144;

    localparam logic [WORTH_W-1:0] WORTH_MIN = {1'b1, {(WORTH_W-1){1'b0}}};
    localparam logic [WORTH_W-1:0] WORTH_MAX = {1'b0, {(WORTH_W-1){1'b1}}};
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        entry_t rec;
        logic   none;
        logic   last;
    } hit_t;

    class top_k_scoreboard;
        entry_t      rows[TBL_DEPTH];
        int unsigned filled;
        hit_t        pending_hits[$];
        int unsigned beats_checked;
        int unsigned mismatches;
        int unsigned dropped;

        function new();
            filled = 0;
            beats_checked = 0;
            mismatches = 0;
            dropped = 0;
        endfunction

        // worth descending, then age ascending, then name ascending
        function bit ranks_ahead(entry_t a, entry_t b);
            if (a.worth != b.worth) return $signed(a.worth) > $signed(b.worth);
            if (a.age != b.age) return a.age < b.age;
            return a.name < b.name;
        endfunction

        function bit has_age(int a);
            for (int unsigned i = 0; i < filled; i++) begin
                if (rows[i].age == a) return 1'b1;
            end
            return 1'b0;
        endfunction

        // note one accepted input beat and queue the results it must cause
        function void take_command(logic is_query, logic [IN_DATA_W-1:0] data);
            entry_t      rec;
            entry_t      matched[$];
            int unsigned pos;
            int unsigned want;
            int unsigned lo;
            int unsigned hi;
            hit_t        h;
            rec = data[ENTRY_W-1:0];
            if (is_query == CMD_INSERT) begin
                if (filled >= TBL_DEPTH) begin
                    dropped++;
                    return;
                end
                pos = filled;
                while (pos > 0 && ranks_ahead(rec, rows[pos-1])) begin
                    rows[pos] = rows[pos-1];
                    pos--;
                end
                rows[pos] = rec;
                filled++;
                return;
            end
            want = 32'(data[CNT_LSB +: LIM_W]);
            if (want > TOP_MAX) want = TOP_MAX;
            lo = 32'(data[LO_LSB +: AGE_W]);
            hi = 32'(data[HI_LSB +: AGE_W]);
            for (int unsigned i = 0; i < filled && matched.size() < want; i++) begin
                if (rows[i].age >= lo && rows[i].age <= hi) begin
                    matched.insert(matched.size(), rows[i]);
                end
            end
            if (matched.size() == 0) begin
                h.rec  = '0;
                h.none = 1'b1;
                h.last = 1'b1;
                pending_hits.insert(pending_hits.size(), h);
            end else begin
                foreach (matched[k]) begin
                    h.rec  = matched[k];
                    h.none = 1'b0;
                    h.last = (k == matched.size() - 1);
                    pending_hits.insert(pending_hits.size(), h);
                end
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic none, logic last);
            hit_t   exp_hit;
            entry_t got;
            got = data[ENTRY_W-1:0];
            beats_checked++;
            if (pending_hits.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got name %h age %0d worth %h",
                         $time, got.name, got.age, got.worth);
                return;
            end
            exp_hit = pending_hits.pop_front();
            if (got.name !== exp_hit.rec.name) begin
                mismatches++;
                $display("%0t: out_name expected %h got %h", $time, exp_hit.rec.name, got.name);
            end
            if (got.age !== exp_hit.rec.age) begin
                mismatches++;
                $display("%0t: out_age expected %0d got %0d", $time, exp_hit.rec.age, got.age);
            end
            if (got.worth !== exp_hit.rec.worth) begin
                mismatches++;
                $display("%0t: out_worth expected %h got %h", $time, exp_hit.rec.worth,
                         got.worth);
            end
            if (none !== exp_hit.none) begin
                mismatches++;
                $display("%0t: none_found expected %b got %b", $time, exp_hit.none, none);
            end
            if (last !== exp_hit.last) begin
                mismatches++;
                $display("%0t: last expected %b got %b", $time, exp_hit.last, last);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    top_k_scoreboard sb;
    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;
    int unsigned n_inserts;
    int unsigned n_queries;
    int unsigned cycles;

    sorted_record_top_k_range_query_top #(
        .DEPTH   (TBL_DEPTH),
        .MAX_OUT (TOP_MAX)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     sb.pending_hits.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [NAME_W-1:0] ascii_name(input string s);
        logic [NAME_W-1:0] v;
        v = '0;
        for (int i = 0; i < 8; i++) begin
            v = {v[NAME_W-9:0], (i < s.len()) ? 8'(s[i]) : 8'h00};
        end
        return v;
    endfunction

    function automatic logic [IN_DATA_W-1:0] insert_beat(logic [NAME_W-1:0] name,
                                                         logic [AGE_W-1:0] age,
                                                         logic [WORTH_W-1:0] worth);
        logic [IN_DATA_W-1:0] d;
        // query fields are don't-care on an insert: fill them with noise
        d = '0;
        d[HI_LSB+AGE_W-1:CNT_LSB] = NOISE_W'($urandom);
        d[ENTRY_W-1:0] = {worth, age, name};
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] query_beat(logic [LIM_W-1:0] count,
                                                        logic [AGE_W-1:0] lo,
                                                        logic [AGE_W-1:0] hi);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[ENTRY_W-1:0] = ENTRY_W'({$urandom, $urandom, $urandom});
        d[CNT_LSB +: LIM_W] = count;
        d[LO_LSB +: AGE_W] = lo;
        d[HI_LSB +: AGE_W] = hi;
        return d;
    endfunction

    task automatic push_beat(input logic cmd, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tuser  = cmd;
        do @(posedge aclk); while (!s_tready);
        sb.take_command(cmd, data);
        if (cmd == CMD_QUERY) n_queries++;
        else n_inserts++;
    endtask

    task automatic push_insert(input logic [NAME_W-1:0] name, input logic [AGE_W-1:0] age,
                               input logic [WORTH_W-1:0] worth);
        push_beat(CMD_INSERT, insert_beat(name, age, worth));
    endtask

    task automatic push_query(input logic [LIM_W-1:0] count, input logic [AGE_W-1:0] lo,
                              input logic [AGE_W-1:0] hi);
        push_beat(CMD_QUERY, query_beat(count, lo, hi));
    endtask

    // few names, ages and worths so that ties on every key show up often
    function automatic logic [NAME_W-1:0] pick_name();
        logic [NAME_W-1:0] v;
        int len;
        case ($urandom_range(9))
            0: v = ascii_name("AMY");
            1: v = ascii_name("AMYX");
            2: v = ascii_name("BEN");
            3: v = ascii_name("ZED");
            4, 5, 6: begin
                len = $urandom_range(8, 1);
                v = '0;
                for (int i = 0; i < 8; i++) begin
                    v = {v[NAME_W-9:0], (i < len) ? 8'($urandom_range(126, 32)) : 8'h00};
                end
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [AGE_W-1:0] pick_age();
        if ($urandom_range(1) == 0) return AGE_W'($urandom_range(21, 18));
        return AGE_W'($urandom_range(255));
    endfunction

    function automatic logic [WORTH_W-1:0] pick_worth();
        logic [WORTH_W-1:0] w;
        case ($urandom_range(9))
            0: w = WORTH_MIN;
            1: w = WORTH_MAX;
            2, 3, 4: w = WORTH_W'($urandom_range(4)) - WORTH_W'(2);
            default: w = WORTH_W'($urandom);
        endcase
        return w;
    endfunction

    task automatic random_item();
        logic [LIM_W-1:0] count;
        logic [AGE_W-1:0] lo;
        logic [AGE_W-1:0] hi;
        if ($urandom_range(99) < 55) begin
            push_insert(pick_name(), pick_age(), pick_worth());
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: count = LIM_W'($urandom_range(8, 1));
                7, 8: count = LIM_W'($urandom_range(TOP_MAX, 9));
                default: count = LIM_W'($urandom_range(127));
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    lo = AGE_W'($urandom_range(255));
                    hi = AGE_W'($urandom_range(255, lo));
                end
                5: begin
                    lo = '0;
                    hi = '1;
                end
                6: begin
                    lo = AGE_W'($urandom_range(255, 1));
                    hi = AGE_W'($urandom_range(lo - 1));
                end
                default: begin
                    lo = AGE_W'($urandom_range(21, 18));
                    hi = AGE_W'($urandom_range(21, lo));
                end
            endcase
            push_query(count, lo, hi);
        end
    endtask

    // result side: check accepted beats, throttle tready, serve one long hold
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                for (int held = 0; held < HOLD_LEN; held++) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        int spare_age;
        sb = new();
        n_inserts = 0;
        n_queries = 0;
        hold_req = 1'b0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_INSERT;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, key ties, worth and name extremes, count edges
        push_query(7'd5, 8'd0, 8'd255);
        push_insert(ascii_name("ALICE"), 8'd30, WORTH_W'(1000));
        push_insert('0, 8'd0, WORTH_MAX);
        push_insert('1, 8'd255, WORTH_MIN);
        push_insert(ascii_name("BOB"), 8'd30, WORTH_W'(1000));
        push_insert(ascii_name("AL"), 8'd30, WORTH_W'(1000));
        push_insert(ascii_name("CAROL"), 8'd25, WORTH_W'(1000));
        push_insert(ascii_name("ALICE"), 8'd30, WORTH_W'(1000));
        push_insert(ascii_name("DAVE"), 8'd40, '1);
        push_insert(ascii_name("EVE"), 8'd40, '0);
        push_query(7'd0, 8'd0, 8'd255);
        push_query(7'd1, 8'd0, 8'd255);
        push_query(7'd64, 8'd0, 8'd255);
        push_query(7'd127, 8'd0, 8'd255);
        push_query(7'd10, 8'd30, 8'd30);
        push_query(7'd4, 8'd50, 8'd20);
        push_query(7'd4, 8'd100, 8'd200);
        push_query(7'd3, 8'd0, 8'd0);
        push_query(7'd2, 8'd255, 8'd255);
        push_query(7'd64, 8'd40, 8'd255);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 27; sink_idle_pct = 74; end
                1: begin src_idle_pct = 74; sink_idle_pct = 27; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            if (ph == 2) begin
                // stall the result side and keep feeding big queries behind it
                hold_req = 1'b1;
                repeat (12) push_query(7'd64, 8'd0, 8'd255);
            end
            repeat (PHASE_LEN) random_item();
        end

        // a record at the front of the order and a random one, then wide, tail and empty-range queries
        push_insert('0, 8'd0, WORTH_MAX);
        push_insert(pick_name(), pick_age(), pick_worth());
        push_query(7'd64, 8'd0, 8'd255);
        push_query(7'd127, 8'd254, 8'd255);
        push_query(7'd3, 8'd255, 8'd0);
        spare_age = -1;
        for (int a = 0; a < 256 && spare_age < 0; a++) begin
            if (!sb.has_age(a)) spare_age = a;
        end
        // an age nobody has forces a scan over the whole table
        if (spare_age >= 0) push_query(7'd64, AGE_W'(spare_age), AGE_W'(spare_age));
        @(negedge aclk);
        s_tvalid = 1'b0;

        while (sb.pending_hits.size() != 0) @(posedge aclk);
        repeat (TBL_DEPTH + 16) @(posedge aclk);

        $display("covered %0d inserts (%0d dropped at capacity) and %0d queries",
                 n_inserts, sb.dropped, n_queries);
        $display("checked %0d result beats against a table of %0d records",
                 sb.beats_checked, sb.filled);
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
